// ===== hdl/gnms_pkg.sv =====
package gnms_pkg;

	localparam int GRAD_W = 11;
	localparam int MAG_W = 11;
	localparam int CFG_W = 11;
	localparam int ROW_W = 10;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_DIM = 3;
	localparam int WIDTH_RESET = 640;
	localparam int HEIGHT_RESET = 480;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_IMAGE_WIDTH = 1'b0;
	localparam reg_idx_t REG_IMAGE_HEIGHT = 1'b1;

	typedef logic signed [GRAD_W-1:0] grad_t;
	typedef logic [MAG_W-1:0] mag_t;

	// direction bins, named after the axis the neighbor pair lies on
	typedef enum logic [1:0] {
		BIN_HORZ      = 2'd0,
		BIN_DIAG_DOWN = 2'd1,
		BIN_VERT      = 2'd2,
		BIN_DIAG_UP   = 2'd3
	} bin_t;

	// one column of the line memory: bin and magnitude of row r-1, magnitude of row r-2
	typedef struct packed {
		bin_t bin;
		mag_t mid;
		mag_t top;
	} line_entry_t;

	typedef struct packed {
		logic shift;
		logic interior;
	} win_ctl_t;

	function automatic mag_t magnitude(input grad_t gx, input grad_t gy);
		logic signed [GRAD_W:0] x;
		logic signed [GRAD_W:0] y;
		logic [GRAD_W:0] ax;
		logic [GRAD_W:0] ay;
		logic [GRAD_W:0] s;
		x = {gx[GRAD_W-1], gx};
		y = {gy[GRAD_W-1], gy};
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		s = ax + ay;
		// sum tops out at 2048, which saturates
		if (s[GRAD_W:MAG_W] != '0) begin
			return '1;
		end
		return s[MAG_W-1:0];
	endfunction

	function automatic bin_t direction(input grad_t gx, input grad_t gy);
		logic signed [GRAD_W:0] x;
		logic signed [GRAD_W:0] y;
		bin_t b;
		x = {gx[GRAD_W-1], gx};
		y = {gy[GRAD_W-1], gy};
		// fold into the half plane with angle in [0, 180)
		if (y < 0 || (y == 0 && x < 0)) begin
			x = -x;
			y = -y;
		end
		if (y == 0) begin
			b = BIN_HORZ;
		end else if (x > 0) begin
			b = (y >= x) ? BIN_DIAG_DOWN : BIN_HORZ;
		end else if (x == 0) begin
			b = BIN_VERT;
		end else begin
			b = (y > -x) ? BIN_VERT : BIN_DIAG_UP;
		end
		return b;
	endfunction

endpackage

// ===== hdl/gnms_pixel_if.sv =====
interface gnms_pixel_if;
	logic valid;
	logic ready;
	gnms_pkg::grad_t grad_x;
	gnms_pkg::grad_t grad_y;

	modport source (output valid, output grad_x, output grad_y, input ready);
	modport sink (input valid, input grad_x, input grad_y, output ready);
endinterface

// ===== hdl/gnms_result_if.sv =====
interface gnms_result_if;
	logic valid;
	logic ready;
	gnms_pkg::mag_t thinned_magnitude;
	logic frame_last;

	modport source (output valid, output thinned_magnitude, output frame_last, input ready);
	modport sink (input valid, input thinned_magnitude, input frame_last, output ready);
endinterface

// ===== hdl/gnms_ram.sv =====
module gnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/gnms_window.sv =====
module gnms_window (
	input  logic               clk,
	input  gnms_pkg::win_ctl_t ctl,
	input  gnms_pkg::mag_t     top,
	input  gnms_pkg::mag_t     mid,
	input  gnms_pkg::mag_t     mag,
	input  gnms_pkg::bin_t     entry_bin,
	output gnms_pkg::mag_t     result
);

	localparam int ROW_TOP = 0;
	localparam int ROW_MID = 1;
	localparam int ROW_BOT = 2;

	// two stored columns; the third is the column arriving now
	gnms_pkg::mag_t left_q [3];
	gnms_pkg::mag_t cen_q [3];
	gnms_pkg::bin_t cbin_q;

	gnms_pkg::mag_t right [3];
	gnms_pkg::mag_t ctr;
	gnms_pkg::mag_t n1;
	gnms_pkg::mag_t n2;

	// window seen before the shift is left_q | cen_q | right
	always_comb begin
		right[ROW_TOP] = top;
		right[ROW_MID] = mid;
		right[ROW_BOT] = mag;
		ctr = cen_q[ROW_MID];
		case (cbin_q)
			gnms_pkg::BIN_HORZ: begin
				n1 = left_q[ROW_MID];
				n2 = right[ROW_MID];
			end
			gnms_pkg::BIN_DIAG_DOWN: begin
				n1 = right[ROW_BOT];
				n2 = left_q[ROW_TOP];
			end
			gnms_pkg::BIN_VERT: begin
				n1 = cen_q[ROW_TOP];
				n2 = cen_q[ROW_BOT];
			end
			default: begin
				n1 = left_q[ROW_BOT];
				n2 = right[ROW_TOP];
			end
		endcase
		result = (ctl.interior && ctr > n1 && ctr > n2) ? ctr : '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int k = 0; k < 3; k++) begin
				left_q[k] <= cen_q[k];
				cen_q[k] <= right[k];
			end
			cbin_q <= entry_bin;
		end
	end

endmodule

// ===== hdl/gradient_nonmax_suppression_unit.sv =====
// Canny non-maximum suppression over a 3x3 window. Takes Sobel (grad_x, grad_y) pairs in
// raster order and returns, for each center pixel, its magnitude |gx|+|gy| (saturated to
// 2047) if strictly greater than both neighbors along its quantized direction, else 0.
// The pixel at (r, c) releases the result for (r-1, c-1), so a frame of W x H gives
// (W-1)*(H-1) results; row 0 and column 0 centers give 0, and frame_last marks the last
// one. Throughput is one pixel per clock while the result side keeps up; a pixel's
// result enters the output register when that pixel leaves stage 1, which waits only
// while the output register is still waiting. The rate is set by the single line memory
// (MAX_WIDTH entries: two magnitude rows and one bin row per column), read when a pixel
// is taken and written back as that pixel leaves the first stage. Consecutive accesses
// always hit different columns, so no forwarding is needed. No clearing pass after
// reset. Width or height writes restart the frame and must be made while idle.
module gradient_nonmax_suppression_unit #(
	parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  gnms_pkg::reg_idx_t          cfg_index,
	input  logic [gnms_pkg::CFG_W-1:0]  cfg_data,
	gnms_pixel_if.sink                  pixel_in,
	gnms_result_if.source               result_out
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (AW + 1 > gnms_pkg::CFG_W) ? AW + 1 : gnms_pkg::CFG_W;
	localparam int RST_W = (gnms_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
		: gnms_pkg::WIDTH_RESET;
	localparam logic [AW-1:0] LAST_COL_RST = AW'(RST_W - 1);
	localparam logic [gnms_pkg::ROW_W-1:0] LAST_ROW_RST =
		gnms_pkg::ROW_W'(gnms_pkg::HEIGHT_RESET - 1);

	logic [AW-1:0] last_col_q;
	logic [gnms_pkg::ROW_W-1:0] last_row_q;
	logic [AW-1:0] col_q;
	logic [gnms_pkg::ROW_W-1:0] row_q;

	logic [WW-1:0] cfg_w_ext;
	logic [AW-1:0] cfg_last_col;
	logic [gnms_pkg::ROW_W-1:0] cfg_last_row;

	logic in_fire;
	logic s1_adv;

	logic valid_s1;
	logic [AW-1:0] col_s1;
	gnms_pkg::mag_t mag_s1;
	gnms_pkg::bin_t bin_s1;
	logic produce_s1;
	logic interior_s1;
	logic last_s1;

	logic out_valid_q;
	gnms_pkg::mag_t out_mag_q;
	logic out_last_q;

	gnms_pkg::line_entry_t rd_entry;
	gnms_pkg::line_entry_t wr_entry;
	gnms_pkg::win_ctl_t win_ctl;
	gnms_pkg::mag_t win_result;

	// clamp incoming register values once, at write time
	always_comb begin
		cfg_w_ext = WW'(cfg_data);
		if (cfg_w_ext < WW'(gnms_pkg::MIN_DIM)) begin
			cfg_last_col = AW'(gnms_pkg::MIN_DIM - 1);
		end else if (cfg_w_ext > WW'(MAX_WIDTH)) begin
			cfg_last_col = AW'(MAX_WIDTH - 1);
		end else begin
			cfg_last_col = AW'(cfg_w_ext - WW'(1));
		end
		if (cfg_data < gnms_pkg::CFG_W'(gnms_pkg::MIN_DIM)) begin
			cfg_last_row = gnms_pkg::ROW_W'(gnms_pkg::MIN_DIM - 1);
		end else if (cfg_data > gnms_pkg::CFG_W'(gnms_pkg::MAX_HEIGHT)) begin
			cfg_last_row = gnms_pkg::ROW_W'(gnms_pkg::MAX_HEIGHT - 1);
		end else begin
			cfg_last_row = gnms_pkg::ROW_W'(cfg_data - gnms_pkg::CFG_W'(1));
		end
	end

	// a stage-1 item without a result never waits for the output register
	assign s1_adv = valid_s1 && (!produce_s1 || !out_valid_q || result_out.ready);
	assign pixel_in.ready = !valid_s1 || s1_adv;
	assign in_fire = pixel_in.valid && pixel_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= LAST_COL_RST;
			last_row_q <= LAST_ROW_RST;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				gnms_pkg::REG_IMAGE_WIDTH: last_col_q <= cfg_last_col;
				gnms_pkg::REG_IMAGE_HEIGHT: last_row_q <= cfg_last_row;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_q == last_col_q) begin
				col_q <= '0;
				row_q <= (row_q == last_row_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1 <= col_q;
			mag_s1 <= gnms_pkg::magnitude(pixel_in.grad_x, pixel_in.grad_y);
			bin_s1 <= gnms_pkg::direction(pixel_in.grad_x, pixel_in.grad_y);
			produce_s1 <= (row_q != '0) && (col_q != '0);
			interior_s1 <= (row_q[gnms_pkg::ROW_W-1:1] != '0) && (col_q >= AW'(2));
			last_s1 <= (row_q == last_row_q) && (col_q == last_col_q);
		end
	end

	// row r-1 moves to the r-2 slot, this pixel becomes row r-1
	always_comb begin
		wr_entry.bin = bin_s1;
		wr_entry.mid = mag_s1;
		wr_entry.top = rd_entry.mid;
	end

	gnms_ram #(
		.WIDTH($bits(gnms_pkg::line_entry_t)),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata(wr_entry),
		.re   (in_fire),
		.raddr(col_q),
		.rdata(rd_entry)
	);

	assign win_ctl.shift = s1_adv;
	assign win_ctl.interior = interior_s1;

	gnms_window u_window (
		.clk      (clk),
		.ctl      (win_ctl),
		.top      (rd_entry.top),
		.mid      (rd_entry.mid),
		.mag      (mag_s1),
		.entry_bin(rd_entry.bin),
		.result   (win_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && produce_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && produce_s1) begin
			out_mag_q <= win_result;
			out_last_q <= last_s1;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.thinned_magnitude = out_mag_q;
	assign result_out.frame_last = out_last_q;

	a_cfg_restarts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en |=> (col_q == '0 && row_q == '0))
		else $error("register write did not restart the frame");

	a_counters_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= last_col_q) && (row_q <= last_row_q))
		else $error("position counters beyond frame size");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_adv && produce_s1))
		else $error("result appeared without a producing pixel");

endmodule
